@@ src/linear_probe_hash_flag_table_unit_assert.svh @@
// Assertion macros shared by the hash table modules.
// IMPL checks the consequent in the same cycle, NEXT checks it in the following cycle.
`ifndef LINEAR_PROBE_HASH_FLAG_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_FLAG_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define LPHF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lphf assertion failed");
`define LPHF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lphf assertion failed");
`else
`define LPHF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPHF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/lphf_pkg.sv @@
`default_nettype none
package lphf_pkg;

  localparam int TableDepth  = 1021;
  localparam int KeyChars    = 8;
  localparam int LetterW     = 5;
  localparam int LettersW    = 40;
  localparam int LenW        = 4;
  localparam int FuncW       = 2;
  localparam int Radix       = 26;
  localparam int SlotW       = $clog2(TableDepth);
  localparam int PosW        = $clog2(KeyChars);
  // Horner step value h*26+d stays below 64*TableDepth; six restoring steps reduce it.
  localparam int ReduceSteps = 6;
  localparam int ReduceW     = SlotW + 7;
  localparam int FifoDepth   = 2;
  localparam int FifoPtrW    = $clog2(FifoDepth);
  localparam int FifoCntW    = $clog2(FifoDepth + 1);

  localparam logic [SlotW-1:0] LastSlot = SlotW'(TableDepth - 1);

  localparam logic [FuncW-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FuncW-1:0] FUNC_READ   = 2'd1;
  localparam logic [FuncW-1:0] FUNC_SET    = 2'd2;

  typedef logic [KeyChars-1:0][LetterW-1:0] letter_arr_t;

  typedef struct packed {
    logic [FuncW-1:0]    func;
    logic [LettersW-1:0] key_letters;
    logic [LenW-1:0]     key_length;
  } in_item_t;

  typedef struct packed {
    logic flag;
    logic found;
    logic status;
  } out_item_t;

  // Classified operation handed from the front to the back.
  typedef struct packed {
    logic [FuncW-1:0]    func;
    logic [LettersW-1:0] letters;
    logic [LenW-1:0]     len;
    logic [SlotW-1:0]    home;
  } job_t;

  typedef struct packed {
    logic                valid;
    logic [LettersW-1:0] letters;
    logic [LenW-1:0]     len;
    logic                flag;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage
`default_nettype wire

@@ src/linear_probe_hash_flag_table_unit.sv @@
`default_nettype none
// Channel | Handshake           | Beat payload
// in      | in_valid, in_stall  | in_item_t  {func, key_letters, key_length}
// out     | out_valid, out_stall| out_item_t {flag, found, status}
//
// Front: accepts a key in F_IDLE, hashes one key letter per cycle in F_HASH, then queues the job in F_PUSH.
// Back: reads the home slot, then probes one slot per cycle (up to 1021 slots).
// Reset (rst_n low, synchronous) starts a clear sweep of all 1021 slots; in_stall stays high.
// A result waits in the output register under out_stall while the front keeps
// accepting and hashing; the two-entry queue lets front and back stall apart.
module linear_probe_hash_flag_table_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lphf_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lphf_pkg::out_item_t      out_data
);
  import lphf_pkg::*;

  job_t       push_data, pop_data;
  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;
  back_stat_t back_stat;

  lphf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .back_stat  (back_stat),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lphf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lphf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .back_stat  (back_stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

@@ src/lphf_front.sv @@
`default_nettype none
`include "linear_probe_hash_flag_table_unit_assert.svh"
module lphf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lphf_pkg::in_item_t in_data,
  input  wire lphf_pkg::back_stat_t back_stat,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output lphf_pkg::job_t         push_data
);
  import lphf_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t      state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [LenW-1:0]   len_c;
  letter_arr_t       letters_c;
  letter_arr_t       key_arr;

  // One Horner digit: (h*26 + d) mod TableDepth by restoring subtraction.
  function automatic logic [SlotW-1:0] horner_step(input logic [SlotW-1:0] h,
                                                   input logic [LetterW-1:0] d);
    logic [ReduceW-1:0] x;
    x = ReduceW'(h) * ReduceW'(Radix) + ReduceW'(d);
    for (int k = ReduceSteps - 1; k >= 0; k--) begin
      if (x >= (ReduceW'(TableDepth) << k)) begin
        x = x - (ReduceW'(TableDepth) << k);
      end
    end
    return x[SlotW-1:0];
  endfunction

  assign key_arr    = job_r.letters;
  assign in_stall   = (state_r != F_IDLE) || back_stat.clearing;
  assign push_valid = (state_r == F_PUSH);
  assign push_data  = job_r;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    pos_nxt   = pos_r;
    len_c     = in_data.key_length;
    letters_c = in_data.key_letters;
    if (len_c == '0) begin
      len_c = LenW'(1);
    end else if (len_c > LenW'(KeyChars)) begin
      len_c = LenW'(KeyChars);
    end
    // drop letters past the effective length
    for (int i = 0; i < KeyChars; i++) begin
      if (LenW'(i) >= len_c) begin
        letters_c[i] = '0;
      end
    end
    unique case (state_r)
      F_IDLE: begin
        if (in_valid && !in_stall) begin
          job_nxt.func    = in_data.func;
          job_nxt.letters = letters_c;
          job_nxt.len     = len_c;
          job_nxt.home    = '0;
          pos_nxt         = PosW'(len_c - LenW'(1));
          state_nxt       = F_HASH;
        end
      end
      F_HASH: begin
        // most significant letter first
        job_nxt.home = horner_step(job_r.home, key_arr[pos_r]);
        if (pos_r == '0) begin
          state_nxt = F_PUSH;
        end else begin
          pos_nxt = pos_r - 1'b1;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    pos_r <= pos_nxt;
  end

  `LPHF_ASSERT_NEXT(a_accept_starts_hash, clk, rst_n, in_valid && !in_stall, state_r == F_HASH)
  `LPHF_ASSERT_NEXT(a_key_held_in_hash, clk, rst_n, state_r == F_HASH, $stable(job_r.len))
  `LPHF_ASSERT_NEXT(a_push_frees_front, clk, rst_n, push_valid && push_ready, state_r == F_IDLE)

endmodule
`default_nettype wire

@@ src/lphf_fifo.sv @@
`default_nettype none
module lphf_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire lphf_pkg::job_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output lphf_pkg::job_t      pop_data
);
  import lphf_pkg::*;

  job_t                slots_r [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FifoPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FifoCntW-1:0] cnt_r, cnt_nxt;
  logic                push, pop;

  assign push_ready = (cnt_r != FifoCntW'(FifoDepth));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ src/lphf_back.sv @@
`default_nettype none
`include "linear_probe_hash_flag_table_unit_assert.svh"
module lphf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire lphf_pkg::job_t pop_data,
  output lphf_pkg::back_stat_t back_stat,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lphf_pkg::out_item_t out_data
);
  import lphf_pkg::*;

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_CHECK = 3'b100
  } back_state_t;

  back_state_t      state_r, state_nxt;
  logic [SlotW-1:0] clr_addr_r, clr_addr_nxt;
  job_t             job_r, job_nxt;
  logic [SlotW-1:0] addr_r, addr_nxt;
  logic [SlotW-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  entry_t           mem [TableDepth];
  entry_t           rd_data_r;
  logic             rd_en, wr_en;
  logic [SlotW-1:0] rd_addr, wr_addr;
  entry_t           wr_data;

  logic             hit, empty_slot, done, out_free, finish;
  logic [SlotW-1:0] next_addr;

  assign back_stat.clearing = (state_r == B_CLEAR);
  assign out_valid          = out_valid_r;
  assign out_data           = out_data_r;

  assign hit        = rd_data_r.valid && (rd_data_r.len == job_r.len) &&
                      (rd_data_r.letters == job_r.letters);
  assign empty_slot = !rd_data_r.valid;
  assign done       = hit || empty_slot || (cnt_r == LastSlot);
  assign out_free   = !out_valid_r || !out_stall;
  assign next_addr  = (addr_r == LastSlot) ? '0 : addr_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    job_nxt       = job_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = addr_r;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = rd_data_r;
    pop_ready     = 1'b0;
    finish        = 1'b0;
    unique case (state_r)
      B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
        if (clr_addr_r == LastSlot) begin
          state_nxt = B_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          job_nxt   = pop_data;
          addr_nxt  = pop_data.home;
          cnt_nxt   = '0;
          rd_en     = 1'b1;
          rd_addr   = pop_data.home;
          state_nxt = B_CHECK;
        end
      end
      B_CHECK: begin
        if (!done) begin
          // advance one slot, wrapping at the end
          rd_en    = 1'b1;
          rd_addr  = next_addr;
          addr_nxt = next_addr;
          cnt_nxt  = cnt_r + 1'b1;
        end else if (out_free) begin
          finish        = 1'b1;
          state_nxt     = B_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          priority if (job_r.func == FUNC_INSERT) begin
            if (hit) begin
              out_data_nxt.found = 1'b1;
              out_data_nxt.flag  = rd_data_r.flag;
            end else if (empty_slot) begin
              wr_en           = 1'b1;
              wr_data.valid   = 1'b1;
              wr_data.letters = job_r.letters;
              wr_data.len     = job_r.len;
              wr_data.flag    = 1'b0;
            end else begin
              out_data_nxt.status = 1'b1;
            end
          end else if (job_r.func == FUNC_SET) begin
            if (hit) begin
              wr_en              = 1'b1;
              wr_data.flag       = 1'b1;
              out_data_nxt.found = 1'b1;
              out_data_nxt.flag  = 1'b1;
            end
          end else begin
            // read, and the unused code acts as read
            if (hit) begin
              out_data_nxt.found = 1'b1;
              out_data_nxt.flag  = rd_data_r.flag;
            end
          end
        end
      end
      default: state_nxt = B_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    addr_r     <= addr_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  `LPHF_ASSERT_IMPL(a_no_result_while_clearing, clk, rst_n, state_r == B_CLEAR, !out_valid_r)
  `LPHF_ASSERT_IMPL(a_probe_bound, clk, rst_n, state_r == B_CHECK, cnt_r <= LastSlot)
  `LPHF_ASSERT_NEXT(a_finish_to_idle, clk, rst_n, finish, state_r == B_IDLE && out_valid_r)
  `LPHF_ASSERT_IMPL(a_write_on_finish, clk, rst_n, wr_en && state_r != B_CLEAR, finish)

endmodule
`default_nettype wire
